>>> sv/cvs_pkg.sv
// Package for the streaming scaled 2D convolution block.
// Holds the item structs, the configuration register indexes, the sizes and the reset values.
// It has no dependencies.
package cvs_pkg;

  localparam int MAX_KERNEL = 7;
  localparam int MAX_WIDTH  = 256;

  typedef struct packed {
    logic        func;
    logic [5:0]  weight_index;
    logic [15:0] weight_value;
    logic [15:0] pixel;
  } in_item_t;

  typedef struct packed {
    logic [31:0] result;
    logic        last;
  } out_item_t;

  localparam logic       FUNC_WEIGHT = 1'b0;
  localparam logic       FUNC_PIXEL  = 1'b1;

  localparam logic [1:0] CFG_KERNEL_SIZE  = 2'd0;
  localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_SCALE_FACTOR = 2'd2;

  localparam logic [2:0]  KERNEL_SIZE_RESET  = 3'd5;
  localparam logic [8:0]  IMAGE_WIDTH_RESET  = 9'd32;
  localparam logic [15:0] SCALE_FACTOR_RESET = 16'h7FFF;

endpackage

>>> sv/conv2d_valid_scaled.sv
// Top level of the streaming valid-mode 2D convolution with a Q0.15 scale.
// Kernel weights and line buffers live in two synchronous memories in this module.
// Depends on cvs_pkg.

// A weight load is written straight to the weight memory. For a pixel, the row slot is
// found from the row position, PW bits wide (8 at MAX_WIDTH 256), by a one-bit-per-cycle
// remainder unit, and then the line buffer is written. A pixel that completes a window
// is then accumulated one weight and one line-buffer read per cycle through a memory,
// multiply and accumulate pipeline, followed by the scale multiply and the saturating
// output stage. A finished result is held in the output register, so the next item can be
// taken while it waits for transfer. There is no clearing pass after reset.
module conv2d_valid_scaled
  import cvs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int MK2  = MAX_KERNEL * MAX_KERNEL;
  localparam int KW   = (MK2 > 1) ? $clog2(MK2) : 1;
  localparam int KSW  = $clog2(MAX_KERNEL + 1);
  localparam int PW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int CW   = WW + 1;
  localparam int RAW  = $clog2(MAX_KERNEL * MAX_WIDTH);
  localparam int DCW  = $clog2(PW + 1);
  localparam int SUMW = 32 + $clog2(MK2 + 1);
  localparam int PRW  = SUMW + 16;
  localparam int SHW  = PRW - 15;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MOD, ST_PUT, ST_RUN, ST_DRAIN, ST_SCALE, ST_OUT
  } state_t;

  state_t state_r;

  logic [2:0]  ks_r;
  logic [8:0]  iw_r;
  logic [15:0] scale_r;

  logic [15:0] wmem [MK2];
  logic [15:0] rmem [MAX_KERNEL * MAX_WIDTH];

  logic [PW-1:0]  row_r, col_r;
  logic [PW-1:0]  c_cur_r;
  logic [15:0]    pix_r;
  logic           fire_r, fin_r;
  logic [PW-1:0]  dsh_r;
  logic [DCW-1:0] dcnt_r;
  logic [KSW:0]   rem_r;
  logic [KSW-1:0] kr_r, kc_r, slot_r;
  logic [KW-1:0]  widx_r;
  logic [RAW-1:0] rbase_r;
  logic [PW-1:0]  wcol_r, wcol0_r;
  logic           p1_v_r, p2_v_r;
  logic [15:0]    wrd_r, rrd_r;
  logic [31:0]    mul_r;
  logic signed [SUMW-1:0] acc_r;
  logic signed [PRW-1:0]  prod_r;
  logic           out_valid_r;
  out_item_t      out_data_r;

  logic [KSW-1:0] k_eff;
  logic [WW-1:0]  w_eff;
  logic           accept, issue, last_issue;
  logic [PW-1:0]  r_eff, c_eff, row_nxt, col_nxt;
  logic [CW-1:0]  r1, c1;
  logic [KSW:0]   rem_nxt;
  logic [KSW-1:0] slot0;
  logic [RAW-1:0] raddr, waddr;
  logic signed [SHW-1:0] sh;
  logic [31:0]    sat;

  always_comb begin
    if (ks_r == 3'd0) begin
      k_eff = KSW'(1);
    end else if (32'(ks_r) > MAX_KERNEL) begin
      k_eff = KSW'(MAX_KERNEL);
    end else begin
      k_eff = KSW'(ks_r);
    end
    if (iw_r == 9'd0) begin
      w_eff = WW'(1);
    end else if (32'(iw_r) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(iw_r);
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    r_eff = (CW'(row_r) >= CW'(w_eff)) ? '0 : row_r;
    c_eff = (CW'(col_r) >= CW'(w_eff)) ? '0 : col_r;
    r1 = CW'(r_eff) + CW'(1);
    c1 = CW'(c_eff) + CW'(1);
    if (c1 >= CW'(w_eff)) begin
      col_nxt = '0;
      row_nxt = (r1 >= CW'(w_eff)) ? '0 : PW'(r1);
    end else begin
      col_nxt = PW'(c1);
      row_nxt = r_eff;
    end
  end

  always_comb begin
    rem_nxt = {rem_r[KSW-1:0], dsh_r[PW-1]};
    if (rem_nxt >= (KSW+1)'(k_eff)) begin
      rem_nxt = rem_nxt - (KSW+1)'(k_eff);
    end
  end

  assign slot0 = ((KSW+1)'(rem_r) + (KSW+1)'(1) == (KSW+1)'(k_eff)) ? '0
                 : KSW'(rem_r + (KSW+1)'(1));
  assign waddr = RAW'(32'(rem_r) * MAX_WIDTH) + RAW'(c_cur_r);
  assign raddr = rbase_r + RAW'(wcol_r);
  assign issue = (state_r == ST_RUN);
  assign last_issue = issue && (kr_r == k_eff - KSW'(1)) && (kc_r == k_eff - KSW'(1));

  always_comb begin
    sh = SHW'(prod_r >>> 15);
    if (sh[SHW-1:31] == '0 || sh[SHW-1:31] == '1) begin
      sat = sh[31:0];
    end else if (sh[SHW-1]) begin
      sat = 32'h8000_0000;
    end else begin
      sat = 32'h7FFF_FFFF;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_data.func == FUNC_WEIGHT && 32'(in_data.weight_index) < MK2) begin
      wmem[KW'(in_data.weight_index)] <= in_data.weight_value;
    end
    wrd_r <= wmem[widx_r];
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_PUT) begin
      rmem[waddr] <= pix_r;
    end
    rrd_r <= rmem[raddr];
  end

  always_ff @(posedge clk) begin
    mul_r <= 32'($signed(wrd_r) * $signed(rrd_r));
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
    end else begin
      p1_v_r <= issue;
      p2_v_r <= p1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ks_r    <= KERNEL_SIZE_RESET;
      iw_r    <= IMAGE_WIDTH_RESET;
      scale_r <= SCALE_FACTOR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KERNEL_SIZE:  ks_r    <= cfg_wdata[2:0];
        CFG_IMAGE_WIDTH:  iw_r    <= cfg_wdata[8:0];
        CFG_SCALE_FACTOR: scale_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      row_r       <= '0;
      col_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == ST_OUT && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (p2_v_r) begin
        acc_r <= acc_r + {{(SUMW-32){mul_r[31]}}, mul_r};
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            if (in_data.func == FUNC_WEIGHT) begin
              row_r <= '0;
              col_r <= '0;
            end else begin
              c_cur_r <= c_eff;
              dsh_r   <= r_eff;
              pix_r   <= in_data.pixel;
              fire_r  <= (r1 >= CW'(k_eff)) && (c1 >= CW'(k_eff));
              fin_r   <= (r1 >= CW'(k_eff)) && (c1 >= CW'(k_eff))
                         && (r1 == CW'(w_eff)) && (c1 == CW'(w_eff));
              row_r   <= row_nxt;
              col_r   <= col_nxt;
              rem_r   <= '0;
              dcnt_r  <= DCW'(PW);
              state_r <= ST_MOD;
            end
          end
        end
        ST_MOD: begin
          rem_r  <= rem_nxt;
          dsh_r  <= {dsh_r[PW-2:0], 1'b0};
          dcnt_r <= dcnt_r - DCW'(1);
          if (dcnt_r == DCW'(1)) begin
            state_r <= ST_PUT;
          end
        end
        ST_PUT: begin
          slot_r  <= slot0;
          rbase_r <= RAW'(32'(slot0) * MAX_WIDTH);
          wcol0_r <= PW'(CW'(c_cur_r) + CW'(1) - CW'(k_eff));
          wcol_r  <= PW'(CW'(c_cur_r) + CW'(1) - CW'(k_eff));
          kr_r    <= '0;
          kc_r    <= '0;
          widx_r  <= '0;
          acc_r   <= '0;
          state_r <= fire_r ? ST_RUN : ST_IDLE;
        end
        ST_RUN: begin
          widx_r <= widx_r + KW'(1);
          if (kc_r == k_eff - KSW'(1)) begin
            kc_r   <= '0;
            kr_r   <= kr_r + KSW'(1);
            wcol_r <= wcol0_r;
            if (slot_r == k_eff - KSW'(1)) begin
              slot_r  <= '0;
              rbase_r <= '0;
            end else begin
              slot_r  <= slot_r + KSW'(1);
              rbase_r <= rbase_r + RAW'(MAX_WIDTH);
            end
          end else begin
            kc_r   <= kc_r + KSW'(1);
            wcol_r <= wcol_r + PW'(1);
          end
          if (last_issue) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!p1_v_r && !p2_v_r) begin
            state_r <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          prod_r  <= $signed(acc_r) * $signed(scale_r);
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_data_r.result <= sat;
            out_data_r.last   <= fin_r;
            state_r           <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  a_weight_resets_pos: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.func == FUNC_WEIGHT |=> row_r == '0 && col_r == '0)
    else $error("weight load did not reset the image position");

  a_pipe_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    p2_v_r |-> state_r == ST_RUN || state_r == ST_DRAIN)
    else $error("accumulate outside window pass");

  a_scale_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCALE |-> !p1_v_r && !p2_v_r)
    else $error("scale started before accumulation finished");

  a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_PUT |-> rem_r < (KSW+1)'(k_eff))
    else $error("row slot out of range");

  a_no_lost_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_OUT && out_valid_r && out_stall |=> state_r == ST_OUT)
    else $error("result left before output register was free");

endmodule
